[rtl/kdt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdt_pkg: shared types and constants of the key debounce tick unit
// Word layouts, divider reset and reload values and the key pin gather function.
// ----------------------------------------------------------------------------
package kdt_pkg;

  localparam int unsigned NumKeys = 8;

  typedef struct packed {
    logic [7:0] port_d;
    logic [7:0] port_b;
    logic [7:0] press_clear;
    logic       second_clear;
  } tick_t;

  typedef struct packed {
    logic [7:0]  keys_debounced;
    logic [7:0]  keys_pressed;
    logic        second_flag;
    logic        second_pulse;
    logic [63:0] time_tenths;
  } res_t;

  localparam logic [1:0] DivDebounceRst    = 2'd2;
  localparam logic [1:0] DivDebounceReload = 2'd1;
  localparam logic [7:0] DivSecondRst      = 8'd200;
  localparam logic [7:0] DivSecondReload   = 8'd199;
  localparam logic [8:0] DivTenthRst       = 9'd333;
  localparam logic [8:0] DivTenthReload    = 9'd19;

  // key bit map: 7<-D4, 6<-D3, 5<-D2, 4<-D5, 3<-D6, 2<-D7, 1<-B0, 0<-D2
  function automatic logic [NumKeys-1:0] gather_keys(input logic [7:0] pd,
                                                     input logic [7:0] pb);
    logic [NumKeys-1:0] v;
    v = {pd[4], pd[3], pd[2], pd[5], pd[6], pd[7], pb[0], pd[2]};
    return v;
  endfunction

endpackage

[rtl/kdt_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdt_if: valid/ready channels of the key debounce tick unit
// One interface for the tick words and one for the result words.
// ----------------------------------------------------------------------------
interface kdt_tick_if;
  logic       valid;
  logic       ready;
  logic [7:0] port_d;
  logic [7:0] port_b;
  logic [7:0] press_clear;
  logic       second_clear;

  modport source (output valid, output port_d, output port_b, output press_clear,
                  output second_clear, input ready);
  modport sink   (input valid, input port_d, input port_b, input press_clear,
                  input second_clear, output ready);
endinterface

interface kdt_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  keys_debounced;
  logic [7:0]  keys_pressed;
  logic        second_flag;
  logic        second_pulse;
  logic [63:0] time_tenths;

  modport source (output valid, output keys_debounced, output keys_pressed,
                  output second_flag, output second_pulse, output time_tenths,
                  input ready);
  modport sink   (input valid, input keys_debounced, input keys_pressed,
                  input second_flag, input second_pulse, input time_tenths,
                  output ready);
endinterface

[rtl/kdt_in_reg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdt_in_reg: input register for tick words
// Captures one tick word and holds it until the core takes it.
// ----------------------------------------------------------------------------
module kdt_in_reg
  import kdt_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  kdt_tick_if.sink        tick_i,
  input  logic            advance_i,
  output logic            valid_o,
  output tick_t           tick_o
);

  logic  valid_q, valid_d;
  tick_t tick_q;
  logic  load;

  assign tick_i.ready = !valid_q || advance_i;
  assign load         = tick_i.valid && tick_i.ready;
  assign valid_d      = load ? 1'b1 : (advance_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      tick_q <= '{port_d:       tick_i.port_d,
                  port_b:       tick_i.port_b,
                  press_clear:  tick_i.press_clear,
                  second_clear: tick_i.second_clear};
    end
  end

  assign valid_o = valid_q;
  assign tick_o  = tick_q;

endmodule

[rtl/kdt_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdt_core: debounce, press latch and divider state
// Applies one tick word to the state and forms the result word.
// ----------------------------------------------------------------------------
module kdt_core
  import kdt_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  step_i,
  input  tick_t tick_i,
  output res_t  res_o
);

  logic [NumKeys-1:0] cnt_lo_q, cnt_lo_d;
  logic [NumKeys-1:0] cnt_hi_q, cnt_hi_d;
  logic [NumKeys-1:0] deb_q, deb_d;
  logic [NumKeys-1:0] prs_q, prs_d;
  logic               sec_q, sec_d;
  logic [1:0]         div_deb_q, div_deb_d;
  logic [7:0]         div_sec_q, div_sec_d;
  logic [8:0]         div_ten_q, div_ten_d;
  logic [63:0]        tenths_q, tenths_d;
  logic               pulse;

  always_comb begin
    logic [NumKeys-1:0] raw;
    logic [NumKeys-1:0] chg;
    logic [NumKeys-1:0] prs_clr;
    raw       = gather_keys(tick_i.port_d, tick_i.port_b);
    chg       = deb_q ^ ~raw;
    prs_clr   = prs_q & ~tick_i.press_clear;
    cnt_lo_d  = cnt_lo_q;
    cnt_hi_d  = cnt_hi_q;
    deb_d     = deb_q;
    prs_d     = prs_clr;
    sec_d     = sec_q && !tick_i.second_clear;
    pulse     = 1'b0;
    div_deb_d = div_deb_q - 2'd1;
    div_sec_d = div_sec_q - 8'd1;
    div_ten_d = div_ten_q - 9'd1;
    tenths_d  = tenths_q;

    if (div_deb_q == '0) begin
      div_deb_d = DivDebounceReload;
      cnt_lo_d  = ~(cnt_lo_q & chg);
      cnt_hi_d  = cnt_lo_d ^ (cnt_hi_q & chg);
      chg       = chg & cnt_lo_d & cnt_hi_d;
      deb_d     = deb_q ^ chg;
      prs_d     = prs_clr | (deb_d & chg);
    end

    if (div_sec_q == '0) begin
      div_sec_d = DivSecondReload;
      sec_d     = 1'b1;
      pulse     = 1'b1;
    end

    if (div_ten_q == '0) begin
      div_ten_d = DivTenthReload;
      tenths_d  = tenths_q + 64'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_lo_q  <= '0;
      cnt_hi_q  <= '0;
      deb_q     <= '0;
      prs_q     <= '0;
      sec_q     <= 1'b0;
      div_deb_q <= DivDebounceRst;
      div_sec_q <= DivSecondRst;
      div_ten_q <= DivTenthRst;
      tenths_q  <= '0;
    end else if (step_i) begin
      cnt_lo_q  <= cnt_lo_d;
      cnt_hi_q  <= cnt_hi_d;
      deb_q     <= deb_d;
      prs_q     <= prs_d;
      sec_q     <= sec_d;
      div_deb_q <= div_deb_d;
      div_sec_q <= div_sec_d;
      div_ten_q <= div_ten_d;
      tenths_q  <= tenths_d;
    end
  end

  assign res_o = '{keys_debounced: deb_d,
                   keys_pressed:   prs_d,
                   second_flag:    sec_d,
                   second_pulse:   pulse,
                   time_tenths:    tenths_d};

endmodule

[rtl/kdt_out_reg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdt_out_reg: result register
// Holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module kdt_out_reg
  import kdt_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  res_t          res_i,
  output logic          free_o,
  kdt_result_if.source  result_o
);

  logic valid_q, valid_d;
  res_t res_q;

  assign free_o  = !valid_q || result_o.ready;
  assign valid_d = load_i ? 1'b1 : (result_o.ready ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign result_o.valid          = valid_q;
  assign result_o.keys_debounced = res_q.keys_debounced;
  assign result_o.keys_pressed   = res_q.keys_pressed;
  assign result_o.second_flag    = res_q.second_flag;
  assign result_o.second_pulse   = res_q.second_pulse;
  assign result_o.time_tenths    = res_q.time_tenths;

endmodule

[rtl/key_debounce_tick_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_debounce_tick_unit: eight-key debouncer with second and tenth dividers
// Each tick word is one 5 ms tick carrying the raw port D and port B pins,
// a mask of consumed presses and a seconds flag clear. Each tick yields one
// result word: debounced keys, latched presses, seconds flag and pulse, and
// a 64-bit count of tenths of a second.
// Channels: tick_i (sink) and result_o (source), valid/ready; a word moves
// when valid and ready are both high.
// Path: a taken tick word passes the input register, then the state update
// and the result register, which offers the result word.
// Throughput: one tick word per cycle while the receiver takes results; the
// state update between the two registers is combinational.
// Reset: counters, debounced keys, presses and the seconds flag clear; the
// dividers load their first-period values. Both registers come up empty.
// Stall: while the receiver holds ready low, the result register holds its
// word, one further tick waits in the input register, then tick_i.ready
// drops. No word is lost or repeated.
// ----------------------------------------------------------------------------
module key_debounce_tick_unit
  import kdt_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  kdt_tick_if.sink      tick_i,
  kdt_result_if.source  result_o
);

  logic  in_valid;
  tick_t tick;
  res_t  res;
  logic  out_free;
  logic  advance;

  assign advance = in_valid && out_free;

  kdt_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tick_i    (tick_i),
    .advance_i (advance),
    .valid_o   (in_valid),
    .tick_o    (tick)
  );

  kdt_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .tick_i (tick),
    .res_o  (res)
  );

  kdt_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance),
    .res_i    (res),
    .free_o   (out_free),
    .result_o (result_o)
  );

endmodule

[sim/kdt_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdt_checker: result predictor and scoreboard for the key debounce tick unit
// Watches both channels. Each tick word taken by the block advances a private
// copy of the debounce counters, press latch, seconds flag and all three dividers.
// The expected result word is queued. Each result word taken from the block
// is compared field by field with the oldest queued word.
// ----------------------------------------------------------------------------
module kdt_checker
  import kdt_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  kdt_tick_if          tick_mon,
  kdt_result_if        result_mon,
  output int unsigned  fail_count_o,
  output int unsigned  pending_o
);

  logic [7:0]  cnt_lo;
  logic [7:0]  cnt_hi;
  logic [7:0]  keys_deb;
  logic [7:0]  keys_prs;
  logic        sec_flag;
  logic [1:0]  div_deb;
  logic [7:0]  div_sec;
  logic [8:0]  div_tenth;
  logic [63:0] tenths;

  res_t        queued_results[$];
  int unsigned fail_count;
  int unsigned pending_cnt;

  assign fail_count_o = fail_count;
  assign pending_o    = pending_cnt;

  task automatic advance_tick(input logic [7:0] pd, input logic [7:0] pb,
                              input logic [7:0] pclr, input logic sclr,
                              output res_t r);
    logic [7:0] raw;
    logic [7:0] chg;
    logic       pulse;
    pulse = 1'b0;
    keys_prs = keys_prs & ~pclr;
    if (sclr) begin
      sec_flag = 1'b0;
    end
    if (div_deb == 2'd0) begin
      raw = {pd[4], pd[3], pd[2], pd[5], pd[6], pd[7], pb[0], pd[2]};
      chg = keys_deb ^ ~raw;
      div_deb = DivDebounceReload;
      cnt_lo = ~(cnt_lo & chg);
      cnt_hi = cnt_lo ^ (cnt_hi & chg);
      chg = chg & cnt_lo & cnt_hi;
      keys_deb = keys_deb ^ chg;
      keys_prs = keys_prs | (keys_deb & chg);
    end else begin
      div_deb = div_deb - 2'd1;
    end
    if (div_sec == 8'd0) begin
      div_sec = DivSecondReload;
      sec_flag = 1'b1;
      pulse = 1'b1;
    end else begin
      div_sec = div_sec - 8'd1;
    end
    if (div_tenth == 9'd0) begin
      div_tenth = DivTenthReload;
      tenths = tenths + 64'd1;
    end else begin
      div_tenth = div_tenth - 9'd1;
    end
    r.keys_debounced = keys_deb;
    r.keys_pressed   = keys_prs;
    r.second_flag    = sec_flag;
    r.second_pulse   = pulse;
    r.time_tenths    = tenths;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want_r;
    res_t next_r;
    if (!rst_ni) begin
      cnt_lo      = '0;
      cnt_hi      = '0;
      keys_deb    = '0;
      keys_prs    = '0;
      sec_flag    = 1'b0;
      div_deb     = DivDebounceRst;
      div_sec     = DivSecondRst;
      div_tenth   = DivTenthRst;
      tenths      = '0;
      fail_count  = 0;
      pending_cnt = 0;
      queued_results.delete();
    end else begin
      if (result_mon.valid && result_mon.ready) begin
        if (queued_results.size() == 0) begin
          $error("result word with no tick outstanding");
          fail_count++;
        end else begin
          want_r = queued_results.pop_front();
          check_field("keys_debounced", 64'(want_r.keys_debounced),
                      64'(result_mon.keys_debounced));
          check_field("keys_pressed", 64'(want_r.keys_pressed),
                      64'(result_mon.keys_pressed));
          check_field("second_flag", 64'(want_r.second_flag),
                      64'(result_mon.second_flag));
          check_field("second_pulse", 64'(want_r.second_pulse),
                      64'(result_mon.second_pulse));
          check_field("time_tenths", want_r.time_tenths, result_mon.time_tenths);
        end
      end
      if (tick_mon.valid && tick_mon.ready) begin
        advance_tick(tick_mon.port_d, tick_mon.port_b, tick_mon.press_clear,
                     tick_mon.second_clear, next_r);
        queued_results.push_back(next_r);
      end
      pending_cnt = queued_results.size();
    end
  end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench top of the key debounce tick unit
// Drives tick words: a directed opening run of press, clear and release, then
// held key patterns with random unused pins, contact bounce, press clears and
// seconds flag clears on divider boundaries. Stalls both channels at random
// and gives the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_top;
  import kdt_pkg::*;

  localparam int unsigned RandomTicks = 1600;
  localparam int unsigned IdlePct     = 34;
  localparam int unsigned StallLimit  = 1000;

  logic        clk_i;
  logic        rst_ni;
  logic        no_idle;
  int unsigned ticks_sent;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned quiet_cycles;

  kdt_tick_if   tick_ch();
  kdt_result_if result_ch();

  key_debounce_tick_unit DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tick_i   (tick_ch),
    .result_o (result_ch)
  );

  kdt_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_mon     (tick_ch),
    .result_mon   (result_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    rst_ni                = 1'b0;
    no_idle               = 1'b0;
    tick_ch.valid         = 1'b0;
    tick_ch.port_d        = '0;
    tick_ch.port_b        = '0;
    tick_ch.press_clear   = '0;
    tick_ch.second_clear  = 1'b0;
    result_ch.ready       = 1'b0;
  end

  always @(posedge clk_i) begin
    result_ch.ready <= no_idle || ($urandom_range(99) >= IdlePct);
  end

  task automatic send_tick(input logic [7:0] pd, input logic [7:0] pb,
                           input logic [7:0] pclr, input logic sclr);
    while (!no_idle && $urandom_range(99) < IdlePct) begin
      tick_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    tick_ch.valid        <= 1'b1;
    tick_ch.port_d       <= pd;
    tick_ch.port_b       <= pb;
    tick_ch.press_clear  <= pclr;
    tick_ch.second_clear <= sclr;
    do @(posedge clk_i); while (!tick_ch.ready);
    ticks_sent++;
  endtask

  // abort when neither channel moves a word for too long
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((tick_ch.valid && tick_ch.ready) || (result_ch.valid && result_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("key_debounce_tick_unit verification failed");
    $finish;
  end

  initial begin
    int unsigned sent_random;
    int unsigned hold;
    logic [7:0]  keys;
    logic [7:0]  pd;
    logic [7:0]  pb;
    logic [7:0]  pclr;
    logic        sclr;
    logic        noisy;
    logic        raw_run;
    ticks_sent  = 0;
    sent_random = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // released, then all keys held until debounced
    repeat (3) send_tick(8'hFF, 8'hFF, 8'h00, 1'b0);
    repeat (10) send_tick(8'h00, 8'h00, 8'h00, 1'b0);
    // keys still held with unused pins high; consume every press
    send_tick(8'h03, 8'hFE, 8'hFF, 1'b1);
    // release with unused pins low
    repeat (10) send_tick(8'hFC, 8'h01, 8'h00, 1'b0);
    send_tick(8'hFF, 8'hFF, 8'h55, 1'b1);

    while (sent_random < RandomTicks) begin
      noisy   = ($urandom_range(99) < 15);
      raw_run = ($urandom_range(99) < 10);
      keys    = 8'($urandom_range(255));
      hold    = $urandom_range(30, 4);
      for (int i = 0; i < hold && sent_random < RandomTicks; i++) begin
        pd = 8'($urandom_range(255));
        pb = 8'($urandom_range(255));
        if (!raw_run) begin
          pd[7:2] = ~{keys[2], keys[3], keys[4], keys[7], keys[6], keys[5]};
          pb[0]   = ~keys[1];
          if (noisy && $urandom_range(99) < 30) begin
            pd[7:2] = pd[7:2] ^ 6'($urandom_range(63));
            pb[0]   = pb[0] ^ 1'($urandom_range(1));
          end
        end
        pclr = ($urandom_range(99) < 20) ? 8'($urandom_range(255)) : 8'h00;
        // hit the tick on which the seconds divider expires
        sclr = ((ticks_sent + 1) % 200 == 1 && ticks_sent > 0) || ($urandom_range(99) < 3);
        no_idle = (sent_random >= 500 && sent_random < 900);
        send_tick(pd, pb, pclr, sclr);
        sent_random++;
      end
    end
    tick_ch.valid <= 1'b0;
    no_idle = 1'b0;

    while (pending != 0) begin
      @(posedge clk_i);
    end
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("key_debounce_tick_unit verification clean");
    end else begin
      $display("key_debounce_tick_unit verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/kdt_pkg.sv
rtl/kdt_if.sv
rtl/kdt_in_reg.sv
rtl/kdt_core.sv
rtl/kdt_out_reg.sv
rtl/key_debounce_tick_unit.sv
sim/kdt_checker.sv
sim/tb_top.sv
